### rtl/core/grid_min_cost_path_macros.svh
// Assertion macros shared by the grid path modules.
`ifndef GRID_MIN_COST_PATH_MACROS_SVH
`define GRID_MIN_COST_PATH_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define GMCP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("grid path assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define GMCP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grid path assertion failed");

`endif

### rtl/core/gmcp_pkg.sv
// Package with constants, payload types and helpers of the grid path block.
`timescale 1ns / 1ps
package gmcp_pkg;

	localparam int GRID_SIDE  = 16;
	localparam int CELLS      = GRID_SIDE * GRID_SIDE;
	localparam int ADDR_W     = $clog2(CELLS);
	localparam int MOVE_DEPTH = 30;
	localparam int MIDX_W     = $clog2(MOVE_DEPTH + 1);
	localparam int MV_AW      = $clog2(MOVE_DEPTH);
	localparam int COORD_W    = 4;
	localparam int CELL_W     = 8;
	localparam int COST_W     = 13;
	localparam int MOVE_W     = 2;
	localparam int PADDR_W    = 4;
	localparam int PDATA_W    = 32;

	localparam logic [MOVE_W-1:0] MV_NONE  = 2'd0;
	localparam logic [MOVE_W-1:0] MV_DOWN  = 2'd1;
	localparam logic [MOVE_W-1:0] MV_RIGHT = 2'd2;
	localparam logic [MOVE_W-1:0] MV_DIAG  = 2'd3;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_SOLVE = 1'b1;

	localparam logic [1:0] REG_START_ROW = 2'd0;
	localparam logic [1:0] REG_START_COL = 2'd1;
	localparam logic [1:0] REG_GOAL_ROW  = 2'd2;
	localparam logic [1:0] REG_GOAL_COL  = 2'd3;

	// Kind of result sequence handed to the emitter
	localparam logic [1:0] K_MOVES  = 2'd0;
	localparam logic [1:0] K_SINGLE = 2'd1;
	localparam logic [1:0] K_ERROR  = 2'd2;

	typedef struct packed {
		logic               action;
		logic [COORD_W-1:0] cell_row;
		logic [COORD_W-1:0] cell_col;
		logic [CELL_W-1:0]  cell_cost;
	} item_t;

	typedef struct packed {
		logic [MOVE_W-1:0] step_move;
		logic [COST_W-1:0] path_cost;
		logic              bad_goal;
		logic              last_move;
	} result_t;

	typedef struct packed {
		logic [COORD_W-1:0] start_row;
		logic [COORD_W-1:0] start_col;
		logic [COORD_W-1:0] goal_row;
		logic [COORD_W-1:0] goal_col;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [MIDX_W-1:0] idx;
		logic [MOVE_W-1:0] mv;
	} trace_wr_t;

	typedef struct packed {
		logic              start;
		logic [1:0]        kind;
		logic [COST_W-1:0] total;
		logic [MIDX_W-1:0] count;
	} emit_req_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] r,
			input logic [COORD_W-1:0] c);
		cell_addr = ADDR_W'(int'(r) * GRID_SIDE + int'(c));
	endfunction

	function automatic logic coord_ok(input logic [COORD_W-1:0] v);
		coord_ok = int'(v) < GRID_SIDE;
	endfunction

endpackage

### rtl/core/grid_min_cost_path.sv
// Top level of the minimum-cost grid path block.
//
//   channel   direction   handshake                 payload
//   item      in          item_valid / item_stall   item_t (action, cell, cost)
//   result    out         result_valid / result_stall  result_t (move, cost, flags)
//   config    in          APB psel/penable/pready   start and goal cell registers
//
// Loads are accepted back to back. A solve holds the input from acceptance to
// the next accepted item: one cell per cycle in the sweep, bounded by the single
// read port of the best-cost memory, then S_TCUR, S_TUP, S_TLEFT and S_TDEC per
// traced move and E_RD then E_LD per replayed result (a one-cell route skips the
// traceback, a goal above or left of start also skips the sweep). No item is taken
// after a solve until its last result is loaded into the output register; a stalled
// result holds that register and the replay, and so the input, behind it.
// Reset clears control state only; the memories hold whatever was last written.
`timescale 1ns / 1ps
module grid_min_cost_path import gmcp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  item_t              item,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t      cfg;
	trace_wr_t trace;
	emit_req_t req;
	logic      emit_busy;

	gmcp_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gmcp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg        (cfg),
		.trace      (trace),
		.req        (req),
		.emit_busy  (emit_busy)
	);

	gmcp_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.trace        (trace),
		.req          (req),
		.emit_busy    (emit_busy),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### rtl/core/gmcp_apb.sv
// APB register file holding the start and goal cells.
`timescale 1ns / 1ps
module gmcp_apb import gmcp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_row <= '0;
			cfg_q.start_col <= '0;
			cfg_q.goal_row  <= COORD_W'(15);
			cfg_q.goal_col  <= COORD_W'(15);
		end else if (wr_en) begin
			case (reg_idx)
				REG_START_ROW: cfg_q.start_row <= pwdata[COORD_W-1:0];
				REG_START_COL: cfg_q.start_col <= pwdata[COORD_W-1:0];
				REG_GOAL_ROW:  cfg_q.goal_row  <= pwdata[COORD_W-1:0];
				REG_GOAL_COL:  cfg_q.goal_col  <= pwdata[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_START_ROW: prdata = PDATA_W'(cfg_q.start_row);
			REG_START_COL: prdata = PDATA_W'(cfg_q.start_col);
			REG_GOAL_ROW:  prdata = PDATA_W'(cfg_q.goal_row);
			REG_GOAL_COL:  prdata = PDATA_W'(cfg_q.goal_col);
			default:       prdata = '0;
		endcase
	end

endmodule

### rtl/core/gmcp_core.sv
// Cost and best-cost memories with the sweep pipeline and traceback sequencer.
`timescale 1ns / 1ps
`include "grid_min_cost_path_macros.svh"
module gmcp_core import gmcp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  item_t     item,
	input  cfg_t      cfg,
	output trace_wr_t trace,
	output emit_req_t req,
	input  logic      emit_busy
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SWEEP = 4'd1;
	localparam logic [3:0] S_DRAIN = 4'd2;
	localparam logic [3:0] S_TOT   = 4'd3;
	localparam logic [3:0] S_TOTW  = 4'd4;
	localparam logic [3:0] S_TCUR  = 4'd5;
	localparam logic [3:0] S_TUP   = 4'd6;
	localparam logic [3:0] S_TLEFT = 4'd7;
	localparam logic [3:0] S_TDEC  = 4'd8;
	localparam logic [3:0] S_HAND  = 4'd9;
	localparam logic [3:0] S_WAIT  = 4'd10;

	logic [CELL_W-1:0] cost_mem [CELLS];
	logic [COST_W-1:0] best_mem [CELLS];

	logic [3:0]         state_q;
	logic [COORD_W-1:0] r_q, c_q;
	logic [MIDX_W-1:0]  n_q;
	logic [1:0]         kind_q;
	logic [COST_W-1:0]  total_q, cur_q, up_q, left_q, diag_q;
	logic [CELL_W-1:0]  here_q, cost_rd_q;
	logic [COST_W-1:0]  best_rd_q;

	logic              valid_s1, first_row_s1, first_col_s1, fwd_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [COST_W-1:0] fwd_val_s1;

	logic               accept, cost_we, bad_goal;
	logic [COORD_W-1:0] r_dec, c_dec;
	logic [ADDR_W-1:0]  cost_raddr, best_raddr;
	logic [COST_W-1:0]  up_val, best_new;
	logic               up_ok, left_ok;
	logic [MOVE_W-1:0]  dec_mv;
	logic [COORD_W-1:0] dec_r, dec_c;

	assign item_stall = state_q != S_IDLE;
	assign accept     = item_valid && !item_stall;
	assign cost_we    = accept && item.action == ACT_LOAD &&
		coord_ok(item.cell_row) && coord_ok(item.cell_col);
	assign bad_goal   = !coord_ok(cfg.start_row) || !coord_ok(cfg.start_col) ||
		!coord_ok(cfg.goal_row) || !coord_ok(cfg.goal_col) ||
		cfg.goal_row < cfg.start_row || cfg.goal_col < cfg.start_col;

	assign r_dec      = r_q - COORD_W'(1);
	assign c_dec      = c_q - COORD_W'(1);
	assign cost_raddr = cell_addr(r_q, c_q);

	always_comb begin
		case (state_q)
			S_SWEEP: best_raddr = cell_addr(r_dec, c_q);
			S_TOT:   best_raddr = cell_addr(cfg.goal_row, cfg.goal_col);
			S_TUP:   best_raddr = cell_addr(r_dec, c_q);
			S_TLEFT: best_raddr = cell_addr(r_q, c_dec);
			default: best_raddr = cell_addr(r_q, c_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (cost_we) begin
			cost_mem[cell_addr(item.cell_row, item.cell_col)] <= item.cell_cost;
		end
		cost_rd_q <= cost_mem[cost_raddr];
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			best_mem[addr_s1] <= best_new;
		end
		best_rd_q <= best_mem[best_raddr];
	end

	// Sweep stage 1: best of up, left and diagonal plus this cell's cost
	always_comb begin
		logic [COST_W-1:0] mn_ul;
		logic [COST_W-1:0] mn;
		logic [COST_W:0]   sum;
		up_val = fwd_s1 ? fwd_val_s1 : best_rd_q;
		mn_ul  = (up_val < left_q) ? up_val : left_q;
		if (first_row_s1 && first_col_s1) begin
			mn = '0;
		end else if (first_row_s1) begin
			mn = left_q;
		end else if (first_col_s1) begin
			mn = up_val;
		end else begin
			mn = (diag_q < mn_ul) ? diag_q : mn_ul;
		end
		sum      = (COST_W + 1)'(mn) + (COST_W + 1)'(cost_rd_q);
		best_new = sum[COST_W-1:0];
	end

	// Traceback decision: try up, then left, then diagonal
	always_comb begin
		logic [COST_W:0] up_sum;
		logic [COST_W:0] left_sum;
		up_sum   = (COST_W + 1)'(up_q) + (COST_W + 1)'(here_q);
		left_sum = (COST_W + 1)'(best_rd_q) + (COST_W + 1)'(here_q);
		up_ok    = r_q > cfg.start_row && cur_q == up_sum[COST_W-1:0];
		left_ok  = c_q > cfg.start_col && cur_q == left_sum[COST_W-1:0];
		dec_r    = r_q;
		dec_c    = c_q;
		if (up_ok) begin
			dec_mv = MV_DOWN;
			dec_r  = r_dec;
		end else if (left_ok) begin
			dec_mv = MV_RIGHT;
			dec_c  = c_dec;
		end else if (r_q > cfg.start_row && c_q > cfg.start_col) begin
			dec_mv = MV_DIAG;
			dec_r  = r_dec;
			dec_c  = c_dec;
		end else if (r_q > cfg.start_row) begin
			dec_mv = MV_DOWN;
			dec_r  = r_dec;
		end else begin
			dec_mv = MV_RIGHT;
			dec_c  = c_dec;
		end
	end

	assign trace.we  = state_q == S_TDEC;
	assign trace.idx = n_q;
	assign trace.mv  = dec_mv;

	assign req.start = state_q == S_HAND;
	assign req.kind  = kind_q;
	assign req.total = total_q;
	assign req.count = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			valid_s1 <= 1'b0;
			r_q      <= '0;
			c_q      <= '0;
			n_q      <= '0;
			kind_q   <= K_MOVES;
		end else begin
			valid_s1 <= state_q == S_SWEEP;
			case (state_q)
				S_IDLE: begin
					if (accept && item.action == ACT_SOLVE) begin
						if (bad_goal) begin
							kind_q  <= K_ERROR;
							state_q <= S_HAND;
						end else begin
							r_q     <= cfg.start_row;
							c_q     <= cfg.start_col;
							state_q <= S_SWEEP;
						end
					end
				end
				S_SWEEP: begin
					if (c_q == cfg.goal_col) begin
						c_q <= cfg.start_col;
						if (r_q == cfg.goal_row) begin
							state_q <= S_DRAIN;
						end else begin
							r_q <= r_q + COORD_W'(1);
						end
					end else begin
						c_q <= c_q + COORD_W'(1);
					end
				end
				S_DRAIN: state_q <= S_TOT;
				S_TOT:   state_q <= S_TOTW;
				S_TOTW: begin
					r_q <= cfg.goal_row;
					c_q <= cfg.goal_col;
					n_q <= '0;
					if (cfg.goal_row == cfg.start_row && cfg.goal_col == cfg.start_col) begin
						kind_q  <= K_SINGLE;
						state_q <= S_HAND;
					end else begin
						state_q <= S_TCUR;
					end
				end
				S_TCUR: begin
					if ((r_q == cfg.start_row && c_q == cfg.start_col) ||
						n_q == MIDX_W'(MOVE_DEPTH)) begin
						kind_q  <= K_MOVES;
						state_q <= S_HAND;
					end else begin
						state_q <= S_TUP;
					end
				end
				S_TUP:   state_q <= S_TLEFT;
				S_TLEFT: state_q <= S_TDEC;
				S_TDEC: begin
					r_q     <= dec_r;
					c_q     <= dec_c;
					n_q     <= n_q + MIDX_W'(1);
					state_q <= S_TCUR;
				end
				S_HAND: state_q <= S_WAIT;
				S_WAIT: begin
					if (!emit_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers of the sweep and traceback
	always_ff @(posedge clk) begin
		addr_s1      <= cell_addr(r_q, c_q);
		first_row_s1 <= r_q == cfg.start_row;
		first_col_s1 <= c_q == cfg.start_col;
		// forward a best cost that is written in the cycle it is read back
		fwd_s1       <= valid_s1 && best_raddr == addr_s1;
		fwd_val_s1   <= best_new;
		if (valid_s1) begin
			left_q <= best_new;
			diag_q <= up_val;
		end
		if (state_q == S_TOTW) begin
			total_q <= best_rd_q;
		end
		if (state_q == S_TUP) begin
			cur_q  <= best_rd_q;
			here_q <= cost_rd_q;
		end
		if (state_q == S_TLEFT) begin
			up_q <= best_rd_q;
		end
	end

	`GMCP_ASSERT_SAME(a_s1_in_sweep, valid_s1, state_q == S_SWEEP || state_q == S_DRAIN)
	`GMCP_ASSERT_SAME(a_trace_depth, trace.we, n_q < MIDX_W'(MOVE_DEPTH))
	`GMCP_ASSERT_NEXT(a_hand_busy, req.start, emit_busy)

endmodule

### rtl/core/gmcp_emit.sv
// Move buffer and output register that replay the traced path start-first.
`timescale 1ns / 1ps
`include "grid_min_cost_path_macros.svh"
module gmcp_emit import gmcp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  trace_wr_t trace,
	input  emit_req_t req,
	output logic      emit_busy,
	output logic      result_valid,
	input  logic      result_stall,
	output result_t   result
);

	localparam logic [1:0] E_IDLE = 2'd0;
	localparam logic [1:0] E_RD   = 2'd1;
	localparam logic [1:0] E_LD   = 2'd2;

	logic [MOVE_W-1:0] move_mem [MOVE_DEPTH];

	logic [1:0]        state_q;
	logic [1:0]        kind_q;
	logic [COST_W-1:0] total_q;
	logic [MIDX_W-1:0] idx_q;
	logic [MOVE_W-1:0] move_rd_q;
	logic              out_valid_q;
	result_t           out_q;
	logic              load, final_ld;
	result_t           next_res;

	assign emit_busy    = state_q != E_IDLE;
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign load         = state_q == E_LD && (!out_valid_q || !result_stall);
	assign final_ld     = kind_q != K_MOVES || idx_q == '0;

	always_comb begin
		next_res.step_move = (kind_q == K_MOVES) ? move_rd_q : MV_NONE;
		next_res.path_cost = (kind_q == K_ERROR) ? '0 : total_q;
		next_res.bad_goal  = kind_q == K_ERROR;
		next_res.last_move = final_ld;
	end

	always_ff @(posedge clk) begin
		if (trace.we) begin
			move_mem[trace.idx[MV_AW-1:0]] <= trace.mv;
		end
		if (state_q == E_RD) begin
			move_rd_q <= move_mem[idx_q[MV_AW-1:0]];
		end
		if (req.start) begin
			kind_q  <= req.kind;
			total_q <= req.total;
		end
		if (load) begin
			out_q <= next_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= E_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				E_IDLE: begin
					if (req.start) begin
						// moves were stored goal-first: replay from the top down
						idx_q   <= req.count - MIDX_W'(1);
						state_q <= (req.kind == K_MOVES) ? E_RD : E_LD;
					end
				end
				E_RD: state_q <= E_LD;
				E_LD: begin
					if (load) begin
						if (final_ld) begin
							state_q <= E_IDLE;
						end else begin
							idx_q   <= idx_q - MIDX_W'(1);
							state_q <= E_RD;
						end
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	`GMCP_ASSERT_SAME(a_start_idle, req.start, state_q == E_IDLE)
	`GMCP_ASSERT_NEXT(a_rd_then_ld, state_q == E_RD, state_q == E_LD)
	`GMCP_ASSERT_SAME(a_idx_range, state_q != E_IDLE && kind_q == K_MOVES, idx_q < MIDX_W'(MOVE_DEPTH))

endmodule

### sim/tb_grid_min_cost_path.sv
// Self-checking testbench for the grid path block: directed and random transactions.
`timescale 1ns / 1ps
module tb_grid_min_cost_path;
	import gmcp_pkg::*;

	localparam int MAX_WAIT        = 18;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int SETTLE_CYCLES   = 20;
	localparam int DRAIN_CYCLES    = 100;
	localparam int RANDOM_ITEMS    = 310;
	localparam int COST_MASK       = (1 << COST_W) - 1;
	localparam int SIDE_MAX        = GRID_SIDE - 1;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               item_valid   = 1'b0;
	logic               item_stall;
	item_t              item         = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	result_t            result;
	logic               psel         = 1'b0;
	logic               penable      = 1'b0;
	logic               pwrite       = 1'b0;
	logic [PADDR_W-1:0] paddr        = '0;
	logic [PDATA_W-1:0] pwdata       = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	item_t             item_queue[$];
	result_t           expected_moves[$];
	result_t           oldest;
	logic [CELL_W-1:0] cell_costs [CELLS];
	logic [COST_W-1:0] best_costs [CELLS];
	bit                cell_written [CELLS];
	cfg_t              route = '{start_row: 4'd0, start_col: 4'd0, goal_row: 4'd15,
		goal_col: 4'd15};

	int mismatches    = 0;
	int results_seen  = 0;
	int generated     = 0;
	int send_wait     = 0;
	int recv_wait     = 0;
	int idle_cycles   = 0;
	bit send_burst    = 1'b0;
	bit recv_burst    = 1'b0;
	bit hold_off_done = 1'b0;

	grid_min_cost_path u_dut (.*);

	initial forever #5 clk = ~clk;

	function automatic int cell_index(input int r, input int c);
		return r * GRID_SIDE + c;
	endfunction

	function automatic int next_wait(inout bit burst);
		if ($urandom_range(0, 15) == 0)
			burst = !burst;
		return burst ? 0 : int'($urandom_range(0, MAX_WAIT));
	endfunction

	function automatic int draw_cost(input int span);
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 255;
			default: return $urandom_range(0, span);
		endcase
	endfunction

	function automatic result_t make_result(input logic [MOVE_W-1:0] mv, input int cost,
			input logic bad, input logic last);
		result_t res;
		res.step_move = mv;
		res.path_cost = COST_W'(cost);
		res.bad_goal  = bad;
		res.last_move = last;
		return res;
	endfunction

	// Sweep the route rectangle, trace back from the goal, queue the moves start-first.
	task automatic solve_route(input item_t it);
		int sr, sc, gr, gc, r, c, n, best, t, here, total;
		logic [MOVE_W-1:0] trail [MOVE_DEPTH];
		sr = route.start_row;
		sc = route.start_col;
		gr = route.goal_row;
		gc = route.goal_col;
		if (it.action == ACT_LOAD) begin
			cell_costs[cell_index(it.cell_row, it.cell_col)] = it.cell_cost;
			return;
		end
		if (gr < sr || gc < sc) begin
			expected_moves.insert(expected_moves.size(), make_result(MV_NONE, 0, 1'b1, 1'b1));
			return;
		end
		for (r = sr; r <= gr; r++)
			for (c = sc; c <= gc; c++) begin
				here = cell_costs[cell_index(r, c)];
				if (r == sr && c == sc) begin
					best = here;
				end else begin
					best = 1 << 30;
					if (r > sr) begin
						t = best_costs[cell_index(r - 1, c)] + here;
						if (t < best) best = t;
					end
					if (c > sc) begin
						t = best_costs[cell_index(r, c - 1)] + here;
						if (t < best) best = t;
					end
					if (r > sr && c > sc) begin
						t = best_costs[cell_index(r - 1, c - 1)] + here;
						if (t < best) best = t;
					end
				end
				best_costs[cell_index(r, c)] = COST_W'(best);
			end
		total = best_costs[cell_index(gr, gc)];
		if (gr == sr && gc == sc) begin
			expected_moves.insert(expected_moves.size(),
				make_result(MV_NONE, total, 1'b0, 1'b1));
			return;
		end
		r = gr;
		c = gc;
		n = 0;
		// prefer up, then left, then diagonal when walking back
		while ((r != sr || c != sc) && n < MOVE_DEPTH) begin
			t = best_costs[cell_index(r, c)];
			here = cell_costs[cell_index(r, c)];
			if (r > sr && t == ((best_costs[cell_index(r - 1, c)] + here) & COST_MASK)) begin
				r--;
				trail[n] = MV_DOWN;
			end else if (c > sc &&
					t == ((best_costs[cell_index(r, c - 1)] + here) & COST_MASK)) begin
				c--;
				trail[n] = MV_RIGHT;
			end else if (r > sr && c > sc) begin
				r--;
				c--;
				trail[n] = MV_DIAG;
			end else if (r > sr) begin
				r--;
				trail[n] = MV_DOWN;
			end else begin
				c--;
				trail[n] = MV_RIGHT;
			end
			n++;
		end
		for (int i = n - 1; i >= 0; i--)
			expected_moves.insert(expected_moves.size(),
				make_result(trail[i], total, 1'b0, i == 0));
	endtask

	task automatic queue_load(input int r, input int c, input int cost);
		item_t it;
		it.action    = ACT_LOAD;
		it.cell_row  = COORD_W'(r);
		it.cell_col  = COORD_W'(c);
		it.cell_cost = CELL_W'(cost);
		item_queue.insert(item_queue.size(), it);
		cell_written[cell_index(r, c)] = 1'b1;
		generated++;
	endtask

	task automatic queue_solve();
		item_t it;
		it.action    = ACT_SOLVE;
		it.cell_row  = COORD_W'($urandom);
		it.cell_col  = COORD_W'($urandom);
		it.cell_cost = CELL_W'($urandom);
		item_queue.insert(item_queue.size(), it);
		generated++;
	endtask

	task automatic wait_idle(input int settle);
		@(negedge clk);
		while (item_queue.size() != 0 || item_valid || expected_moves.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input int value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * index);
		pwdata  <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (index)
			REG_START_ROW: route.start_row = COORD_W'(value);
			REG_START_COL: route.start_col = COORD_W'(value);
			REG_GOAL_ROW:  route.goal_row  = COORD_W'(value);
			REG_GOAL_COL:  route.goal_col  = COORD_W'(value);
			default: ;
		endcase
	endtask

	task automatic set_route(input int sr, input int sc, input int gr, input int gc);
		wait_idle(SETTLE_CYCLES);
		write_reg(REG_START_ROW, sr);
		write_reg(REG_START_COL, sc);
		write_reg(REG_GOAL_ROW, gr);
		write_reg(REG_GOAL_COL, gc);
		@(negedge clk);
	endtask

	// One route, loads over its rectangle (none for a bad goal), then two to four solves.
	task automatic random_phase();
		int kind, span, dr, dc, sr, sc, gr, gc;
		kind = $urandom_range(0, 7);
		case ($urandom_range(0, 2))
			0: span = 1;
			1: span = 15;
			default: span = 255;
		endcase
		if (kind == 0) begin
			// goal above or left of start
			sr = $urandom_range(0, SIDE_MAX);
			sc = $urandom_range(0, SIDE_MAX);
			gr = $urandom_range(0, SIDE_MAX);
			gc = $urandom_range(0, SIDE_MAX);
			if ($urandom_range(0, 1)) begin
				sr = $urandom_range(1, SIDE_MAX);
				gr = $urandom_range(0, sr - 1);
			end else begin
				sc = $urandom_range(1, SIDE_MAX);
				gc = $urandom_range(0, sc - 1);
			end
		end else begin
			if (kind == 1) begin
				dr = 0;
				dc = 0;
			end else if ($urandom_range(0, 5) == 0) begin
				dr = $urandom_range(5, SIDE_MAX);
				dc = $urandom_range(0, 1);
				if ($urandom_range(0, 1)) begin
					dc = dr;
					dr = $urandom_range(0, 1);
				end
			end else begin
				dr = $urandom_range(0, 4);
				dc = $urandom_range(0, 4);
				if (dr == 0 && dc == 0) dc = 1;
			end
			sr = $urandom_range(0, SIDE_MAX - dr);
			sc = $urandom_range(0, SIDE_MAX - dc);
			gr = sr + dr;
			gc = sc + dc;
		end
		set_route(sr, sc, gr, gc);
		repeat ($urandom_range(0, 2))
			queue_load($urandom_range(0, SIDE_MAX), $urandom_range(0, SIDE_MAX), draw_cost(255));
		if (kind != 0)
			for (int r = sr; r <= gr; r++)
				for (int c = sc; c <= gc; c++)
					if (!cell_written[cell_index(r, c)] || $urandom_range(0, 2) == 0)
						queue_load(r, c, draw_cost(span));
		queue_solve();
		repeat ($urandom_range(1, 3)) begin
			repeat ($urandom_range(0, 4))
				if (kind != 0)
					queue_load($urandom_range(sr, gr), $urandom_range(sc, gc), draw_cost(span));
				else
					queue_load($urandom_range(0, SIDE_MAX), $urandom_range(0, SIDE_MAX),
						draw_cost(span));
			queue_solve();
		end
	endtask

	// Sender: present queued transactions, hold while stalled, idle between them.
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			send_wait  <= 0;
		end else begin
			if (item_valid && !item_stall)
				solve_route(item);
			if (!item_valid || !item_stall) begin
				if (send_wait != 0) begin
					item_valid <= 1'b0;
					send_wait  <= send_wait - 1;
				end else if (item_queue.size() != 0) begin
					item       <= item_queue.pop_front();
					item_valid <= 1'b1;
					send_wait  <= next_wait(send_burst);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each result against the oldest expectation, stall at random.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			recv_wait = 0;
		end else begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (expected_moves.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: move %0d cost %0d bad %0b last %0b",
							result.step_move, result.path_cost, result.bad_goal,
							result.last_move);
				end else begin
					oldest = expected_moves.pop_front();
					if (result.step_move !== oldest.step_move ||
							result.path_cost !== oldest.path_cost ||
							result.bad_goal !== oldest.bad_goal ||
							result.last_move !== oldest.last_move) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("result mismatch: expected move %0d cost %0d bad %0b last %0b, ",
								oldest.step_move, oldest.path_cost, oldest.bad_goal,
								oldest.last_move);
							$display("got move %0d cost %0d bad %0b last %0b",
								result.step_move, result.path_cost, result.bad_goal,
								result.last_move);
						end
					end
				end
				recv_wait = next_wait(recv_burst);
			end else if (recv_wait != 0) begin
				recv_wait--;
			end
			// hold off once while the sender still has plenty queued
			if (!hold_off_done && results_seen >= 10 && item_queue.size() > 8) begin
				recv_wait = HOLD_OFF_CYCLES;
				hold_off_done = 1'b1;
			end
			result_stall <= (recv_wait != 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall) || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// single-cell route at the far corner
		set_route(15, 15, 15, 15);
		queue_load(15, 15, 255);
		queue_solve();
		queue_load(15, 15, 0);
		queue_solve();
		// goal above or left of start
		set_route(15, 15, 0, 0);
		queue_solve();
		set_route(3, 5, 4, 2);
		queue_solve();
		set_route(5, 3, 2, 8);
		queue_solve();
		// all-zero 2x2 ties, then a cheap diagonal
		set_route(0, 0, 1, 1);
		queue_load(0, 0, 0);
		queue_load(0, 1, 0);
		queue_load(1, 0, 0);
		queue_load(1, 1, 0);
		queue_solve();
		queue_load(0, 1, 200);
		queue_load(1, 0, 200);
		queue_solve();

		while (generated < RANDOM_ITEMS)
			random_phase();

		wait_idle(DRAIN_CYCLES);
		if (mismatches == 0 && expected_moves.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/gmcp_pkg.sv
rtl/core/gmcp_apb.sv
rtl/core/gmcp_core.sv
rtl/core/gmcp_emit.sv
rtl/core/grid_min_cost_path.sv
sim/tb_grid_min_cost_path.sv
